@@ sv/huffman_code_builder_encoder_top_assert.svh @@
// Assertion macros for the Huffman code builder and encoder.
// Taken in by the top level; the macros expand against its clk and rst_n.
`ifndef HUFFMAN_CODE_BUILDER_ENCODER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked property, switched off while reset is asserted.
`define HCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hcbe assertion failed");
// Checked property, also sampled during reset.
`define HCB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hcbe assertion failed");
`else
`define HCB_ASSERT(lbl, prop)
`define HCB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/hcbe_pkg.sv @@
// Shared types and constants of the Huffman code builder and encoder.
// No dependencies; used by the top level.
`default_nettype none

package hcbe_pkg;

  localparam int CMD_W     = 2;
  localparam int SYM_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CODE_W    = 19;
  localparam int LEN_OUT_W = 5;

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT  = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Status codes returned with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_CODE  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CODE_W-1:0]    code;
    logic [LEN_OUT_W-1:0] code_length;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_ENCODE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_HEAP_CHK,
    ST_HP_RD,
    ST_HP_LD,
    ST_SD_L,
    ST_SD_LW,
    ST_SD_RW,
    ST_SD_MOVE,
    ST_MERGE,
    ST_TK0,
    ST_TK1,
    ST_TK2,
    ST_SU,
    ST_SU_W,
    ST_ROOT0,
    ST_ROOT1,
    ST_WK,
    ST_WK_D,
    ST_DONE
  } state_t;

  // Where a sift-down returns to when it finishes.
  typedef enum logic [1:0] {
    RET_HEAPIFY,
    RET_TAKE1,
    RET_TAKE2
  } ret_t;

endpackage

`default_nettype wire

@@ sv/hcbe_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module hcbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a same-address read returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/huffman_code_builder_encoder_top.sv @@
// Huffman code builder and encoder over a byte alphabet: top level.
// Depends on hcbe_pkg, hcbe_ram and huffman_code_builder_encoder_top_assert.svh.
`default_nettype none

// Each input item gives one result item. A count item reads the histogram,
// writes the incremented count back and then hands over its result, and an
// encode item reads the code table and then hands over its result; a result
// waits in ST_DONE until the output register is free. A build item runs
// a sequencer over the histogram, heap and node memories: it scans the
// histogram, heapifies and merges the used symbols with sift-downs and
// sift-ups, then walks the tree depth-first to fill the code table; each memory
// has one read and one write port, and that single heap port sets the build
// time. After reset the block clears the whole histogram before it accepts
// an item.
// A finished result waits in an output register while the next item is taken.
module huffman_code_builder_encoder_top
  import hcbe_pkg::*;
#(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_BITS = 19,
  parameter int COUNT_BITS    = 24
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam int NODES = 2 * ALPHABET_SIZE - 1;
  localparam int NW    = $clog2(NODES);
  localparam int WW    = COUNT_BITS + AW;
  localparam int HW    = AW + 1;
  localparam int PW    = AW + 2;
  localparam int LW    = $clog2(MAX_CODE_BITS + 2);
  localparam int STK_D = MAX_CODE_BITS + 1;
  localparam int SIW   = $clog2(STK_D);
  localparam int SPW   = $clog2(STK_D + 1);

  typedef struct packed {
    logic [WW-1:0] weight;
    logic [NW-1:0] node;
  } heap_ent_t;

  typedef struct packed {
    logic          leaf;
    logic [AW-1:0] sym;
    logic [NW-1:0] br0;
    logic [NW-1:0] br1;
  } node_ent_t;

  typedef struct packed {
    logic                     present;
    logic [MAX_CODE_BITS-1:0] code;
    logic [LW-1:0]            len;
  } code_ent_t;

  // Registers.
  state_t                   state_r, state_nxt;
  ret_t                     ret_r, ret_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;
  out_item_t                res_r, res_nxt;
  logic                     table_ready_r, table_ready_nxt;
  logic [HW-1:0]            idx_r, idx_nxt;
  logic [HW-1:0]            hs_r, hs_nxt;
  logic [NW-1:0]            nc_r, nc_nxt;
  logic [AW-1:0]            sym_r, sym_nxt;
  logic                     sym_ok_r, sym_ok_nxt;
  logic                     sc_vld_r, sc_vld_nxt;
  logic [AW-1:0]            sc_sym_r, sc_sym_nxt;
  heap_ent_t                cur_r, cur_nxt;
  heap_ent_t                best_r, best_nxt;
  heap_ent_t                top_r, top_nxt;
  heap_ent_t                a_r, a_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [PW-1:0]            mpos_r, mpos_nxt;
  logic [NW-1:0]            wn_r, wn_nxt;
  logic [LW-1:0]            wd_r, wd_nxt;
  logic [MAX_CODE_BITS-1:0] wc_r, wc_nxt;
  logic [SPW-1:0]           sp_r, sp_nxt;
  logic [NW-1:0]            stk_node_r [STK_D];
  logic [LW-1:0]            stk_dep_r  [STK_D];
  logic [MAX_CODE_BITS-1:0] stk_code_r [STK_D];

  // Memory ports.
  logic                  h_we;
  logic [AW-1:0]         h_waddr, h_raddr;
  logic [COUNT_BITS-1:0] h_wdata, h_rdata;
  logic                  hp_we;
  logic [AW-1:0]         hp_waddr, hp_raddr;
  heap_ent_t             hp_wdata, hp_rdata;
  logic                  n_we;
  logic [NW-1:0]         n_waddr, n_raddr;
  node_ent_t             n_wdata, n_rdata;
  logic                  c_we;
  logic [AW-1:0]         c_waddr, c_raddr;
  code_ent_t             c_wdata, c_rdata;

  // Stack push control.
  logic                     stk_we;
  logic [NW-1:0]            stk_wnode;
  logic [LW-1:0]            stk_wdep;
  logic [MAX_CODE_BITS-1:0] stk_wcode;

  // Helpers.
  logic          sd_done;
  logic [PW-1:0] lpos, rpos, ppos;
  logic [HW-1:0] hsm1;
  logic [SIW-1:0] sp_top;

  hcbe_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET_SIZE)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  hcbe_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(ALPHABET_SIZE)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hp_raddr), .rdata(hp_rdata)
  );

  hcbe_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  hcbe_ram #(.WIDTH($bits(code_ent_t)), .DEPTH(ALPHABET_SIZE)) u_code (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lpos   = (pos_r << 1) + PW'(1);
  assign rpos   = lpos + PW'(1);
  assign ppos   = (pos_r - PW'(1)) >> 1;
  assign hsm1   = hs_r - HW'(1);
  assign sp_top = SIW'(sp_r - SPW'(1));

  // Sequencer: next state, memory controls and result.
  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    res_nxt         = res_r;
    table_ready_nxt = table_ready_r;
    idx_nxt         = idx_r;
    hs_nxt          = hs_r;
    nc_nxt          = nc_r;
    sym_nxt         = sym_r;
    sym_ok_nxt      = sym_ok_r;
    sc_vld_nxt      = sc_vld_r;
    sc_sym_nxt      = sc_sym_r;
    cur_nxt         = cur_r;
    best_nxt        = best_r;
    top_nxt         = top_r;
    a_nxt           = a_r;
    pos_nxt         = pos_r;
    mpos_nxt        = mpos_r;
    wn_nxt          = wn_r;
    wd_nxt          = wd_r;
    wc_nxt          = wc_r;
    sp_nxt          = sp_r;
    sd_done         = 1'b0;
    h_we            = 1'b0;
    h_waddr         = sym_r;
    h_wdata         = '0;
    h_raddr         = in_data.symbol[AW-1:0];
    hp_we           = 1'b0;
    hp_waddr        = pos_r[AW-1:0];
    hp_wdata        = cur_r;
    hp_raddr        = '0;
    n_we            = 1'b0;
    n_waddr         = nc_r;
    n_wdata         = '0;
    n_raddr         = wn_r;
    c_we            = 1'b0;
    c_waddr         = idx_r[AW-1:0];
    c_wdata         = '0;
    c_raddr         = in_data.symbol[AW-1:0];
    stk_we          = 1'b0;
    stk_wnode       = n_rdata.br1;
    stk_wdep        = wd_r + LW'(1);
    stk_wcode       = {wc_r[MAX_CODE_BITS-2:0], 1'b1};

    case (state_r)
      // Zero the histogram once after reset.
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = idx_r[AW-1:0];
        idx_nxt = idx_r + HW'(1);
        if (idx_r == HW'(ALPHABET_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take an item and start its first memory access.
      ST_IDLE: begin
        if (in_valid) begin
          sym_nxt    = in_data.symbol[AW-1:0];
          sym_ok_nxt = ({1'b0, in_data.symbol} < 9'(ALPHABET_SIZE));
          res_nxt    = '0;
          case (in_data.command)
            CMD_COUNT:  state_nxt = ST_COUNT;
            CMD_ENCODE: state_nxt = ST_ENCODE;
            CMD_BUILD: begin
              idx_nxt         = '0;
              hs_nxt          = '0;
              nc_nxt          = '0;
              sc_vld_nxt      = 1'b0;
              table_ready_nxt = 1'b0;
              state_nxt       = ST_SCAN;
            end
            default:    state_nxt = ST_DONE;
          endcase
        end
      end

      // Saturating histogram increment.
      ST_COUNT: begin
        if (sym_ok_r && (h_rdata != '1)) begin
          h_we    = 1'b1;
          h_wdata = h_rdata + COUNT_BITS'(1);
        end
        state_nxt = ST_DONE;
      end

      // Code table lookup.
      ST_ENCODE: begin
        if (table_ready_r && sym_ok_r && c_rdata.present) begin
          res_nxt.status      = STAT_OK;
          res_nxt.code        = CODE_W'(c_rdata.code);
          res_nxt.code_length = LEN_OUT_W'(c_rdata.len);
        end else begin
          res_nxt.status = STAT_NO_CODE;
        end
        state_nxt = ST_DONE;
      end

      // Read the histogram in order, clear the code table, and make a
      // leaf plus a heap slot for every used symbol.
      ST_SCAN, ST_SCAN_LAST: begin
        if (state_r == ST_SCAN) begin
          h_raddr    = idx_r[AW-1:0];
          c_we       = 1'b1;
          sc_vld_nxt = 1'b1;
          sc_sym_nxt = idx_r[AW-1:0];
          idx_nxt    = idx_r + HW'(1);
          if (idx_r == HW'(ALPHABET_SIZE - 1)) begin
            state_nxt = ST_SCAN_LAST;
          end
        end else begin
          state_nxt = ST_HEAP_CHK;
        end
        if (sc_vld_r && (h_rdata != '0)) begin
          n_we          = 1'b1;
          n_wdata.leaf  = 1'b1;
          n_wdata.sym   = sc_sym_r;
          hp_we         = 1'b1;
          hp_waddr      = hs_r[AW-1:0];
          hp_wdata      = '{weight: WW'(h_rdata), node: nc_r};
          hs_nxt        = hs_r + HW'(1);
          nc_nxt        = nc_r + NW'(1);
        end
      end

      // Empty histogram check, then heapify from the last parent down.
      ST_HEAP_CHK: begin
        if (hs_r == '0) begin
          res_nxt.status = STAT_EMPTY;
          state_nxt      = ST_DONE;
        end else begin
          idx_nxt   = hsm1 >> 1;
          state_nxt = ST_HP_RD;
        end
      end

      ST_HP_RD: begin
        hp_raddr  = idx_r[AW-1:0];
        state_nxt = ST_HP_LD;
      end

      ST_HP_LD: begin
        cur_nxt   = hp_rdata;
        pos_nxt   = PW'(idx_r);
        ret_nxt   = RET_HEAPIFY;
        state_nxt = ST_SD_L;
      end

      // Sift-down with a moving hole: the sifted entry stays in cur_r.
      ST_SD_L: begin
        if (lpos < PW'(hs_r)) begin
          hp_raddr  = lpos[AW-1:0];
          state_nxt = ST_SD_LW;
        end else begin
          hp_we   = 1'b1;
          sd_done = 1'b1;
        end
      end

      ST_SD_LW: begin
        if (hp_rdata.weight < cur_r.weight) begin
          best_nxt = hp_rdata;
          mpos_nxt = lpos;
        end else begin
          best_nxt = cur_r;
          mpos_nxt = pos_r;
        end
        if (rpos < PW'(hs_r)) begin
          hp_raddr  = rpos[AW-1:0];
          state_nxt = ST_SD_RW;
        end else begin
          state_nxt = ST_SD_MOVE;
        end
      end

      ST_SD_RW: begin
        if (hp_rdata.weight < best_r.weight) begin
          best_nxt = hp_rdata;
          mpos_nxt = rpos;
        end
        state_nxt = ST_SD_MOVE;
      end

      ST_SD_MOVE: begin
        hp_we = 1'b1;
        if (mpos_r == pos_r) begin
          sd_done = 1'b1;
        end else begin
          hp_wdata  = best_r;
          pos_nxt   = mpos_r;
          state_nxt = ST_SD_L;
        end
      end

      // Merge loop: take two, push their sum, until one node remains.
      ST_MERGE: begin
        if (hs_r > HW'(1)) begin
          ret_nxt   = RET_TAKE1;
          state_nxt = ST_TK0;
        end else begin
          state_nxt = ST_ROOT0;
        end
      end

      ST_TK0: begin
        hp_raddr  = '0;
        state_nxt = ST_TK1;
      end

      ST_TK1: begin
        top_nxt   = hp_rdata;
        hp_raddr  = hsm1[AW-1:0];
        state_nxt = ST_TK2;
      end

      ST_TK2: begin
        cur_nxt   = hp_rdata;
        hs_nxt    = hsm1;
        pos_nxt   = '0;
        state_nxt = ST_SD_L;
      end

      // Sift-up with a moving hole.
      ST_SU: begin
        if (pos_r == '0) begin
          hp_we     = 1'b1;
          state_nxt = ST_MERGE;
        end else begin
          hp_raddr  = ppos[AW-1:0];
          state_nxt = ST_SU_W;
        end
      end

      ST_SU_W: begin
        hp_we = 1'b1;
        if (cur_r.weight < hp_rdata.weight) begin
          hp_wdata  = hp_rdata;
          pos_nxt   = ppos;
          state_nxt = ST_SU;
        end else begin
          state_nxt = ST_MERGE;
        end
      end

      // Fetch the root and start the depth-first walk.
      ST_ROOT0: begin
        hp_raddr  = '0;
        state_nxt = ST_ROOT1;
      end

      ST_ROOT1: begin
        wn_nxt    = hp_rdata.node;
        wd_nxt    = '0;
        wc_nxt    = '0;
        sp_nxt    = '0;
        state_nxt = ST_WK;
      end

      ST_WK: begin
        if (wd_r > LW'(MAX_CODE_BITS)) begin
          res_nxt.status = STAT_TOO_LONG;
          state_nxt      = ST_DONE;
        end else begin
          n_raddr   = wn_r;
          state_nxt = ST_WK_D;
        end
      end

      // Leaf: store its code, then resume at the last pushed branch 1.
      // Inner node: push branch 1 and descend into branch 0.
      ST_WK_D: begin
        if (n_rdata.leaf) begin
          c_we    = 1'b1;
          c_waddr = n_rdata.sym;
          c_wdata = '{present: 1'b1, code: wc_r, len: wd_r};
          if (sp_r == '0) begin
            table_ready_nxt = 1'b1;
            res_nxt.status  = STAT_OK;
            state_nxt       = ST_DONE;
          end else begin
            wn_nxt    = stk_node_r[sp_top];
            wd_nxt    = stk_dep_r[sp_top];
            wc_nxt    = stk_code_r[sp_top];
            sp_nxt    = sp_r - SPW'(1);
            state_nxt = ST_WK;
          end
        end else begin
          stk_we    = 1'b1;
          sp_nxt    = sp_r + SPW'(1);
          wn_nxt    = n_rdata.br0;
          wd_nxt    = wd_r + LW'(1);
          wc_nxt    = {wc_r[MAX_CODE_BITS-2:0], 1'b0};
          state_nxt = ST_WK;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Return from a finished sift-down.
    if (sd_done) begin
      case (ret_r)
        RET_HEAPIFY: begin
          if (idx_r == '0) begin
            state_nxt = ST_MERGE;
          end else begin
            idx_nxt   = idx_r - HW'(1);
            state_nxt = ST_HP_RD;
          end
        end
        RET_TAKE1: begin
          a_nxt     = top_r;
          ret_nxt   = RET_TAKE2;
          state_nxt = ST_TK0;
        end
        RET_TAKE2: begin
          n_we         = 1'b1;
          n_wdata.leaf = 1'b0;
          n_wdata.br0  = a_r.node;
          n_wdata.br1  = top_r.node;
          cur_nxt      = '{weight: a_r.weight + top_r.weight, node: nc_r};
          nc_nxt       = nc_r + NW'(1);
          pos_nxt      = PW'(hs_r);
          hs_nxt       = hs_r + HW'(1);
          state_nxt    = ST_SU;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      out_valid_r   <= 1'b0;
      table_ready_r <= 1'b0;
      idx_r         <= '0;
      hs_r          <= '0;
      sp_r          <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      table_ready_r <= table_ready_nxt;
      idx_r         <= idx_nxt;
      hs_r          <= hs_nxt;
      sp_r          <= sp_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    nc_r       <= nc_nxt;
    sym_r      <= sym_nxt;
    sym_ok_r   <= sym_ok_nxt;
    sc_vld_r   <= sc_vld_nxt;
    sc_sym_r   <= sc_sym_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    top_r      <= top_nxt;
    a_r        <= a_nxt;
    pos_r      <= pos_nxt;
    mpos_r     <= mpos_nxt;
    wn_r       <= wn_nxt;
    wd_r       <= wd_nxt;
    wc_r       <= wc_nxt;
    if (stk_we) begin
      stk_node_r[sp_r[SIW-1:0]] <= stk_wnode;
      stk_dep_r[sp_r[SIW-1:0]]  <= stk_wdep;
      stk_code_r[sp_r[SIW-1:0]] <= stk_wcode;
    end
  end

`include "huffman_code_builder_encoder_top_assert.svh"

  // The heap never holds more entries than the alphabet.
  `HCB_ASSERT(a_heap_bound, hs_r <= HW'(ALPHABET_SIZE))
  // The walk stack stays within one entry per code bit plus one.
  `HCB_ASSERT(a_stack_bound, sp_r <= SPW'(STK_D))
  // The table only becomes ready at the end of a walk.
  `HCB_ASSERT(a_ready_rise, $rose(table_ready_r) |-> ($past(state_r) == ST_WK_D))
  // An accepted item always leaves the sequencer busy in the cycle after acceptance.
  `HCB_ASSERT(a_accept_busy, (in_valid && in_ready) |=> !in_ready)

endmodule

`default_nettype wire
